[rtl/core/bslpd_pkg.sv]
// Shared types and constants for the button short/long press detector.
`default_nettype none

package bslpd_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int LEVELS_W    = 4;
   localparam int TIME_W      = 32;
   localparam int THRESH_W    = 16;
   localparam int BUTTON_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // buttons past the levels field read as zero (pressed)
   localparam int LEVEL_EXT_W = (NUM_BUTTONS > LEVELS_W) ? NUM_BUTTONS : LEVELS_W;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_LONG_PRESS = 1'b0;
   localparam csr_idx_type CSR_SHORT_MIN  = 1'b1;

   localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd600;
   localparam logic [THRESH_W-1:0] SHORT_MIN_RESET  = 16'd30;

   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   typedef struct packed {
      logic [THRESH_W-1:0] long_press_ms;
      logic [THRESH_W-1:0] short_min_ms;
   } cfg_type;

   typedef struct packed {
      logic                event_valid;
      logic [BUTTON_W-1:0] button;
      logic                event_kind;
   } evt_type;

endpackage

`default_nettype wire

[rtl/core/bslpd_req_if.sv]
// Poll word channel: button levels and millisecond time.
`default_nettype none

interface bslpd_req_if
   import bslpd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [LEVELS_W-1:0] levels;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, output levels, output now_ms, input ready);
   modport sink   (input valid, input levels, input now_ms, output ready);
endinterface

`default_nettype wire

[rtl/core/bslpd_rsp_if.sv]
// Event word channel: one word per poll.
`default_nettype none

interface bslpd_rsp_if
   import bslpd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                event_valid;
   logic [BUTTON_W-1:0] button;
   logic                event_kind;

   modport source (output valid, output event_valid, output button, output event_kind,
                   input ready);
   modport sink   (input valid, input event_valid, input button, input event_kind,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/bslpd_scan.sv]
// Per-button press state and priority scan that picks the first event of a poll.
`default_nettype none

module bslpd_scan
   import bslpd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [LEVELS_W-1:0] levels,
   input  wire logic [TIME_W-1:0]   now_ms,
   input  wire cfg_type             cfg,
   output evt_type                  result
);

   logic [NUM_BUTTONS-1:0] last_level_ff, last_level_in;
   logic [NUM_BUTTONS-1:0] pressed_ff, pressed_in;
   logic [NUM_BUTTONS-1:0] long_rep_ff, long_rep_in;
   logic [TIME_W-1:0]      press_start_ff [NUM_BUTTONS];
   logic [TIME_W-1:0]      press_start_in [NUM_BUTTONS];

   logic [LEVEL_EXT_W-1:0] level_ext;
   logic [NUM_BUTTONS-1:0] lvl, start, long_hit, rel_hit, short_hit;
   logic [TIME_W-1:0]      held [NUM_BUTTONS];
   logic                   hit;

   assign level_ext = LEVEL_EXT_W'(levels);

   // independent per-button checks
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         lvl[i]       = level_ext[i];
         start[i]     = !pressed_ff[i] && !lvl[i];
         held[i]      = start[i] ? '0 : (now_ms - press_start_ff[i]);
         long_hit[i]  = !lvl[i] && !(long_rep_ff[i] && !start[i])
                        && (held[i] >= TIME_W'(cfg.long_press_ms));
         rel_hit[i]   = pressed_ff[i] && lvl[i];
         short_hit[i] = !long_rep_ff[i] && (held[i] > TIME_W'(cfg.short_min_ms));
      end
   end

   // in-order scan; first event freezes the remaining buttons
   always_comb begin
      last_level_in  = last_level_ff;
      pressed_in     = pressed_ff;
      long_rep_in    = long_rep_ff;
      press_start_in = press_start_ff;
      result         = '0;
      hit            = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (!hit) begin
            if (lvl[i] != last_level_ff[i]) begin
               last_level_in[i] = lvl[i];
            end else begin
               if (start[i]) begin
                  pressed_in[i]     = 1'b1;
                  press_start_in[i] = now_ms;
                  long_rep_in[i]    = 1'b0;
               end
               if (long_hit[i]) begin
                  long_rep_in[i]     = 1'b1;
                  result.event_valid = 1'b1;
                  result.button      = BUTTON_W'(i);
                  result.event_kind  = KIND_LONG;
                  hit                = 1'b1;
               end else if (rel_hit[i]) begin
                  pressed_in[i] = 1'b0;
                  if (short_hit[i]) begin
                     result.event_valid = 1'b1;
                     result.button      = BUTTON_W'(i);
                     result.event_kind  = KIND_SHORT;
                     hit                = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= '1;
         pressed_ff    <= '0;
         long_rep_ff   <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_start_ff[i] <= '0;
         end
      end else if (advance) begin
         last_level_ff  <= last_level_in;
         pressed_ff     <= pressed_in;
         long_rep_ff    <= long_rep_in;
         press_start_ff <= press_start_in;
      end
   end

   // an event never comes from a button whose level just changed
   assert property (@(posedge clock) disable iff (reset)
      advance && result.event_valid
         |-> lvl[result.button] == last_level_ff[result.button])
      else $error("event from a button with a changing level");

   // a reported event needs some button pressed or starting a press
   assert property (@(posedge clock) disable iff (reset)
      result.event_valid |-> (pressed_ff | start) != '0)
      else $error("event without any press in progress");

   // scan state only moves when a word advances
   assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(pressed_ff) && $stable(last_level_ff))
      else $error("button state changed without a poll");

endmodule

`default_nettype wire

[rtl/core/button_short_long_press_detector_core.sv]
// Top level of the button short/long press detector.
// Usage:
//   req_ch carries one poll word per handshake: levels (bit i = button i,
//   1 released, 0 pressed) and now_ms, a free-running wrapping ms counter.
//   rsp_ch returns exactly one word per poll: event_valid, button and
//   event_kind (0 short, 1 long); a poll with no event gives all zeros.
//   csr_we/csr_index/csr_wdata write long_press_ms (index 0) and
//   short_min_ms (index 1); write only while no poll is in flight.
// Timing:
//   A poll lands in an input register, then the four button checks and the
//   first-event pick run combinationally into the output register, which
//   drives rsp_ch.valid and the event word; throughput is one word per
//   cycle while rsp_ch.ready stays high.
// Reset:
//   Synchronous, active high. Both registers go empty, thresholds return to
//   600 ms and 30 ms, all buttons read released with no press pending.
// Stall:
//   While rsp_ch.ready is low the result word holds; one more poll may sit
//   in the input register, after which req_ch.ready drops.
`default_nettype none

module button_short_long_press_detector_core
   import bslpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   bslpd_req_if.sink                  req_ch,
   bslpd_rsp_if.source                rsp_ch,
   input  wire logic                  csr_we,
   input  wire csr_idx_type           csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg_ff, cfg_in;

   logic                in_valid_ff, in_valid_in;
   logic [LEVELS_W-1:0] in_levels_ff;
   logic [TIME_W-1:0]   in_now_ff;

   logic                out_valid_ff, out_valid_in;
   evt_type             out_data_ff;
   evt_type             scan_result;

   logic                advance;
   logic                req_take;

   // input word moves on when the output register is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_PRESS: cfg_in.long_press_ms = THRESH_W'(csr_wdata);
            CSR_SHORT_MIN:  cfg_in.short_min_ms  = THRESH_W'(csr_wdata);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   bslpd_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .levels  (in_levels_ff),
      .now_ms  (in_now_ff),
      .cfg     (cfg_ff),
      .result  (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         cfg_ff.short_min_ms  <= SHORT_MIN_RESET;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_levels_ff <= req_ch.levels;
         in_now_ff    <= req_ch.now_ms;
      end
      if (advance) begin
         out_data_ff <= scan_result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.event_valid = out_data_ff.event_valid;
   assign rsp_ch.button      = out_data_ff.button;
   assign rsp_ch.event_kind  = out_data_ff.event_kind;

   // every advanced word shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word lost before output");

   // a held input word with a stalled output blocks new polls
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("poll accepted over a held word");

   // no-event words carry zero button and kind
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.event_valid)
         |-> (out_data_ff.button == '0) && (out_data_ff.event_kind == KIND_SHORT))
      else $error("no-event word with nonzero fields");

   // both stages come out of reset empty
   assert property (@(posedge clock)
      $past(reset) |-> !in_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
